// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the vertex key dedup rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, suspended while reset is high
`define VKD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on every rising edge, suspended while reset is high
`define VKD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/vkd_pkg.sv =====
// package with types and constants of the vertex key dedup table
package vkd_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int SLOT_OUT_W  = 10;
  localparam int SLOT_WIDE_W = (SLOT_W > SLOT_OUT_W) ? SLOT_W : SLOT_OUT_W;

  localparam logic [1:0] OUTCOME_FOUND = 2'd0;
  localparam logic [1:0] OUTCOME_ADDED = 2'd1;
  localparam logic [1:0] OUTCOME_FULL  = 2'd2;

  // packed key, position in the low bits
  typedef struct packed {
    logic [15:0] colour;
    logic [15:0] texcoord;
    logic [15:0] normal;
    logic [14:0] position;
  } key_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic rotate;
    logic append;
    key_t key;
  } ctl_t;

endpackage

// ===== hw/rtl/vkd_cell.sv =====
// one key cell of the rotating key ring
module vkd_cell (
  input  logic          clk,
  input  vkd_pkg::ctl_t ctl,
  input  logic          is_tail,
  input  logic          is_free,
  input  vkd_pkg::key_t next_key,
  input  vkd_pkg::key_t head_key,
  output vkd_pkg::key_t key
);

  always_ff @(posedge clk) begin
    if (ctl.rotate) begin
      // tail cell closes the ring by taking the head key
      key <= is_tail ? head_key : next_key;
    end else if (ctl.append && is_free) begin
      key <= ctl.key;
    end
  end

endmodule

// ===== hw/rtl/vkd_chain.sv =====
// ring of key cells with the one-hot free slot marker
`include "assert_macros.svh"

module vkd_chain (
  input  logic          clk,
  input  logic          rst,
  input  vkd_pkg::ctl_t ctl,
  output vkd_pkg::key_t head_key
);

  logic [vkd_pkg::TABLE_DEPTH:0]   free;
  vkd_pkg::key_t                   keys [vkd_pkg::TABLE_DEPTH];

  // free marks the first unused cell, top bit means table full
  always_ff @(posedge clk) begin
    if (rst) begin
      free <= {{vkd_pkg::TABLE_DEPTH{1'b0}}, 1'b1};
    end else if (ctl.append) begin
      free <= {free[vkd_pkg::TABLE_DEPTH-1:0], 1'b0};
    end
  end

  for (genvar i = 0; i < vkd_pkg::TABLE_DEPTH; i++) begin : g_cell
    vkd_pkg::key_t nb;
    if (i == vkd_pkg::TABLE_DEPTH - 1) begin : g_last
      assign nb = keys[i];
    end else begin : g_mid
      assign nb = keys[i+1];
    end
    vkd_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .is_tail  (free[i+1]),
      .is_free  (free[i]),
      .next_key (nb),
      .head_key (keys[0]),
      .key      (keys[i])
    );
  end

  assign head_key = keys[0];

  `VKD_ASSERT(a_free_onehot, clk, rst, $onehot(free), "free marker not one-hot")
  `VKD_ASSERT_IMPL(a_no_append_full, clk, rst, ctl.append, !free[vkd_pkg::TABLE_DEPTH], "append into full table")
  `VKD_ASSERT_IMPL(a_no_rotate_append, clk, rst, ctl.rotate, !ctl.append, "rotate and append together")

endmodule

// ===== hw/rtl/vertex_key_dedup_table_top.sv =====
// top level of the vertex key dedup table: sequencer, result register and key ring
// a transaction runs a search state, skipped for an empty table, then a finish state that sets done
// one transaction at a time: start is taken only while busy is low
// search length is set by the key ring, which moves one stored key past the head compare a cycle
// reset: synchronous, active high, empties the table and drops busy and done
// results cannot be stalled: each is marked valid only for the single cycle that done is high
`include "assert_macros.svh"

module vertex_key_dedup_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] polygon_number,
  input  logic [1:0]  corner_number,
  input  logic [14:0] position_ref,
  input  logic signed [15:0] normal_ref,
  input  logic signed [15:0] texcoord_ref,
  input  logic signed [15:0] colour_ref,
  output logic        done,
  output logic [15:0] polygon_echo,
  output logic [1:0]  corner_echo,
  output logic [9:0]  unique_slot,
  output logic [1:0]  outcome
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]                   state;
  logic [vkd_pkg::CNT_W-1:0]    count;
  logic [vkd_pkg::SLOT_W-1:0]   step;
  logic [vkd_pkg::SLOT_W-1:0]   slot;
  logic                         hit;
  vkd_pkg::key_t                query;
  logic [15:0]                  polygon_q;
  logic [1:0]                   corner_q;
  vkd_pkg::key_t                head_key;
  vkd_pkg::ctl_t                ctl;
  logic                         accept;
  logic                         full;
  logic                         last_step;
  logic                         match;
  logic [vkd_pkg::SLOT_W-1:0]   slot_next;
  logic [1:0]                   outcome_next;
  logic [vkd_pkg::SLOT_WIDE_W-1:0] slot_wide;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign full      = (count == vkd_pkg::CNT_W'(vkd_pkg::TABLE_DEPTH));
  // ring is back in slot order after exactly count rotations
  assign last_step = ((vkd_pkg::CNT_W'(step) + vkd_pkg::CNT_W'(1)) == count);
  // stored keys are distinct, so at most one step of a search matches
  assign match     = (head_key == query);

  // decision made in the finish cycle
  always_comb begin
    priority if (hit) begin
      outcome_next = vkd_pkg::OUTCOME_FOUND;
      slot_next    = slot;
    end else if (!full) begin
      outcome_next = vkd_pkg::OUTCOME_ADDED;
      slot_next    = count[vkd_pkg::SLOT_W-1:0];
    end else begin
      outcome_next = vkd_pkg::OUTCOME_FULL;
      slot_next    = '0;
    end
  end

  assign slot_wide = vkd_pkg::SLOT_WIDE_W'(slot_next);

  assign ctl.rotate = (state == ST_SEARCH);
  assign ctl.append = (state == ST_FINISH) && !hit && !full;
  assign ctl.key    = query;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            // empty table skips the search
            state <= (count == '0) ? ST_FINISH : ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (last_step) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          state <= ST_IDLE;
          done  <= 1'b1;
          if (ctl.append) begin
            count <= count + vkd_pkg::CNT_W'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // transaction payload and search bookkeeping
  always_ff @(posedge clk) begin
    if (accept) begin
      query.position <= position_ref;
      query.normal   <= normal_ref;
      query.texcoord <= texcoord_ref;
      query.colour   <= colour_ref;
      polygon_q      <= polygon_number;
      corner_q       <= corner_number;
      step           <= '0;
      hit            <= 1'b0;
    end else if (state == ST_SEARCH) begin
      step <= step + vkd_pkg::SLOT_W'(1);
      if (match) begin
        hit  <= 1'b1;
        slot <= step;
      end
    end
  end

  // result register, loaded in the finish state at the same edge that sets done
  always_ff @(posedge clk) begin
    if (state == ST_FINISH) begin
      polygon_echo <= polygon_q;
      corner_echo  <= corner_q;
      unique_slot  <= slot_wide[vkd_pkg::SLOT_OUT_W-1:0];
      outcome      <= outcome_next;
    end
  end

  vkd_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .head_key (head_key)
  );

  `VKD_ASSERT_IMPL(a_done_after_finish, clk, rst, done, $past(state) == ST_FINISH, "done without finish")
  `VKD_ASSERT_IMPL(a_search_nonempty, clk, rst, state == ST_SEARCH, count != '0, "search on empty table")
  `VKD_ASSERT(a_count_bound, clk, rst, count <= vkd_pkg::CNT_W'(vkd_pkg::TABLE_DEPTH), "count beyond depth")
  `VKD_ASSERT_IMPL(a_added_grows, clk, rst, done && outcome == vkd_pkg::OUTCOME_ADDED, count == $past(count) + vkd_pkg::CNT_W'(1), "append did not grow table")

endmodule
